[src/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DPNA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");

// Property must never hold at a clock edge outside reset.
`define DPNA_ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) not (prop)) \
      else $error("%m: forbidden condition seen");

`endif

[src/dpna_pkg.sv]
// Package: types, constants and helpers of the defect pixel neighbor average block.
`timescale 1ns / 1ps
`default_nettype none
package dpna_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH         = 1024;
   localparam int MAX_HEIGHT        = 1024;
   localparam int NEIGHBOR_DISTANCE = 2;
   localparam int MEM_DEPTH         = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W            = $clog2(MEM_DEPTH);

   // Field widths
   localparam int OP_W  = 2;
   localparam int X_W   = 10;
   localparam int Y_W   = 10;
   localparam int PIX_W = 8;
   localparam int SUM_W = PIX_W + 2;
   localparam int CFG_W = 11;
   localparam int IDX_W = 1;

   // Width for frame bound compares
   localparam int MAXDIM_BITS = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int DIM_W       = ((CFG_W > MAXDIM_BITS) ? CFG_W : MAXDIM_BITS) + 1;

   // Register indexes and reset values
   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1024);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_CORRECT = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Store address source
   typedef enum logic [2:0] {
      AS_CENTER = 3'd0,
      AS_RIGHT  = 3'd1,
      AS_LEFT   = 3'd2,
      AS_DOWN   = 3'd3,
      AS_UP     = 3'd4
   } addr_sel_type;

   // Result kind
   typedef enum logic [1:0] {
      RSP_ZERO = 2'd0,
      RSP_OOF  = 2'd1,
      RSP_READ = 2'd2,
      RSP_CORR = 2'd3
   } rsp_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         latch_req;
      addr_sel_type addr_sel;
      logic         mem_we;
      logic         wdata_avg;
      logic         sum_load;
      logic         sum_acc;
      logic         rsp_fire;
      rsp_sel_type  rsp_sel;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      op_type op;
      logic   oof;
      logic   inner;
   } status_type;

   // Linear store address of a pixel
   function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y);
      pix_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
   endfunction

endpackage
`default_nettype wire

[src/dpna_ctrl.sv]
// Controller: sequences load, read, correct and no-op requests over the frame store.
`timescale 1ns / 1ps
`default_nettype none
module dpna_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire dpna_pkg::status_type status,
   output dpna_pkg::cmd_type         cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_READ  = 7'b0000100,
      S_NBR1  = 7'b0001000,
      S_NBR2  = 7'b0010000,
      S_NBR3  = 7'b0100000,
      S_WRITE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = dpna_pkg::AS_CENTER;
      cmd.rsp_sel  = dpna_pkg::RSP_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (status.oof) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_sel  = dpna_pkg::RSP_OOF;
               state_in     = S_IDLE;
            end else if (status.op == dpna_pkg::OP_LOAD) begin
               cmd.mem_we   = 1'b1;
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end else if (status.op == dpna_pkg::OP_READ) begin
               state_in = S_READ;
            end else if (status.op == dpna_pkg::OP_CORRECT && status.inner) begin
               cmd.addr_sel = dpna_pkg::AS_RIGHT;
               state_in     = S_NBR1;
            end else begin
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rsp_fire = 1'b1;
            cmd.rsp_sel  = dpna_pkg::RSP_READ;
            state_in     = S_IDLE;
         end
         S_NBR1: begin
            cmd.addr_sel = dpna_pkg::AS_LEFT;
            cmd.sum_load = 1'b1;
            state_in     = S_NBR2;
         end
         S_NBR2: begin
            cmd.addr_sel = dpna_pkg::AS_DOWN;
            cmd.sum_acc  = 1'b1;
            state_in     = S_NBR3;
         end
         S_NBR3: begin
            cmd.addr_sel = dpna_pkg::AS_UP;
            cmd.sum_acc  = 1'b1;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            cmd.mem_we    = 1'b1;
            cmd.wdata_avg = 1'b1;
            cmd.rsp_fire  = 1'b1;
            cmd.rsp_sel   = dpna_pkg::RSP_CORR;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[src/dpna_datapath.sv]
// Datapath: frame store, configuration registers, bound checks, neighbor sum and result register.
`timescale 1ns / 1ps
`default_nettype none
module dpna_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [dpna_pkg::OP_W-1:0]           req_operation,
   input  wire logic [dpna_pkg::X_W-1:0]            req_pixel_x,
   input  wire logic [dpna_pkg::Y_W-1:0]            req_pixel_y,
   input  wire logic [dpna_pkg::PIX_W-1:0]          req_load_value,
   input  wire logic                                csr_write_enable,
   input  wire logic [dpna_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [dpna_pkg::CFG_W-1:0]          csr_write_data,
   input  wire dpna_pkg::cmd_type                   cmd,
   output dpna_pkg::status_type                     status,
   output logic                                     rsp_strobe,
   output logic [dpna_pkg::PIX_W-1:0]               rsp_pixel_value,
   output logic                                     rsp_was_corrected,
   output logic                                     rsp_out_of_frame
);

   localparam logic [dpna_pkg::DIM_W-1:0] DIST  = dpna_pkg::DIM_W'(dpna_pkg::NEIGHBOR_DISTANCE);
   localparam logic [dpna_pkg::DIM_W-1:0] MAX_W = dpna_pkg::DIM_W'(dpna_pkg::MAX_WIDTH);
   localparam logic [dpna_pkg::DIM_W-1:0] MAX_H = dpna_pkg::DIM_W'(dpna_pkg::MAX_HEIGHT);
   localparam logic [dpna_pkg::X_W-1:0]   DX    = dpna_pkg::X_W'(dpna_pkg::NEIGHBOR_DISTANCE);
   localparam logic [dpna_pkg::Y_W-1:0]   DY    = dpna_pkg::Y_W'(dpna_pkg::NEIGHBOR_DISTANCE);

   logic [dpna_pkg::CFG_W-1:0]  frame_width_ff, frame_height_ff;
   dpna_pkg::op_type            op_ff;
   logic [dpna_pkg::X_W-1:0]    x_ff;
   logic [dpna_pkg::Y_W-1:0]    y_ff;
   logic [dpna_pkg::PIX_W-1:0]  load_ff;
   logic [dpna_pkg::SUM_W-1:0]  sum_ff, sum_in, sum_total;
   logic [dpna_pkg::PIX_W-1:0]  avg;

   logic [dpna_pkg::PIX_W-1:0]  mem [dpna_pkg::MEM_DEPTH];
   logic [dpna_pkg::PIX_W-1:0]  rdata_ff;
   logic [dpna_pkg::ADDR_W-1:0] mem_addr;
   logic [dpna_pkg::PIX_W-1:0]  mem_wdata;

   logic [dpna_pkg::DIM_W-1:0]  w_cfg, h_cfg, w_eff, h_eff, x_ext, y_ext;

   logic                        rsp_strobe_ff;
   logic [dpna_pkg::PIX_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic                        rsp_corr_ff, rsp_corr_in;
   logic                        rsp_oof_ff, rsp_oof_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= dpna_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= dpna_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dpna_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            dpna_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= dpna_pkg::op_type'(req_operation);
         x_ff    <= req_pixel_x;
         y_ff    <= req_pixel_y;
         load_ff <= req_load_value;
      end
   end

   // Saturate frame size and check bounds
   always_comb begin
      w_cfg = dpna_pkg::DIM_W'(frame_width_ff);
      h_cfg = dpna_pkg::DIM_W'(frame_height_ff);
      w_eff = (w_cfg > MAX_W) ? MAX_W : w_cfg;
      h_eff = (h_cfg > MAX_H) ? MAX_H : h_cfg;
      x_ext = dpna_pkg::DIM_W'(x_ff);
      y_ext = dpna_pkg::DIM_W'(y_ff);
      status.op    = op_ff;
      status.oof   = (op_ff != dpna_pkg::OP_NONE) && ((x_ext >= w_eff) || (y_ext >= h_eff));
      status.inner = (x_ext >= DIST) && (y_ext >= DIST) &&
                     ((x_ext + DIST) < w_eff) && ((y_ext + DIST) < h_eff);
   end

   // Select store address and write data
   always_comb begin
      unique case (cmd.addr_sel)
         dpna_pkg::AS_RIGHT: mem_addr = dpna_pkg::pix_addr(x_ff + DX, y_ff);
         dpna_pkg::AS_LEFT:  mem_addr = dpna_pkg::pix_addr(x_ff - DX, y_ff);
         dpna_pkg::AS_DOWN:  mem_addr = dpna_pkg::pix_addr(x_ff, y_ff + DY);
         dpna_pkg::AS_UP:    mem_addr = dpna_pkg::pix_addr(x_ff, y_ff - DY);
         default:            mem_addr = dpna_pkg::pix_addr(x_ff, y_ff);
      endcase
      sum_total = sum_ff + dpna_pkg::SUM_W'(rdata_ff);
      avg       = sum_total[dpna_pkg::SUM_W-1:2];
      mem_wdata = cmd.wdata_avg ? avg : load_ff;
   end

   // Single-port frame store with registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   // Accumulate neighbor values
   always_comb begin
      sum_in = sum_ff;
      if (cmd.sum_load) begin
         sum_in = dpna_pkg::SUM_W'(rdata_ff);
      end else if (cmd.sum_acc) begin
         sum_in = sum_total;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Form the result
   always_comb begin
      rsp_pixel_in = '0;
      rsp_corr_in  = 1'b0;
      rsp_oof_in   = 1'b0;
      unique case (cmd.rsp_sel)
         dpna_pkg::RSP_OOF:  rsp_oof_in = 1'b1;
         dpna_pkg::RSP_READ: rsp_pixel_in = rdata_ff;
         dpna_pkg::RSP_CORR: begin
            rsp_pixel_in = avg;
            rsp_corr_in  = 1'b1;
         end
         default: ;
      endcase
   end

   // Register the result for one strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_fire) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_corr_ff  <= rsp_corr_in;
         rsp_oof_ff   <= rsp_oof_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_pixel_value   = rsp_pixel_ff;
   assign rsp_was_corrected = rsp_corr_ff;
   assign rsp_out_of_frame  = rsp_oof_ff;

endmodule
`default_nettype wire

[src/defect_pixel_neighbor_average_top.sv]
// Sequence: a load, an out-of-frame or a no-op request strobes its result after the check state,
// as does a correction of a pixel closer than the neighbor distance to a frame edge; a read after
// the check and read states; any other correction after four neighbor reads and one write through
// the single port of the frame store. Only one request is in work at a time; busy is already low
// in the strobe cycle, so a new request is taken at the edge that ends it.
// Reset clears the controller, result strobe and frame size registers; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module defect_pixel_neighbor_average_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [dpna_pkg::OP_W-1:0]  req_operation,
   input  wire logic [dpna_pkg::X_W-1:0]   req_pixel_x,
   input  wire logic [dpna_pkg::Y_W-1:0]   req_pixel_y,
   input  wire logic [dpna_pkg::PIX_W-1:0] req_load_value,
   output logic                            rsp_strobe,
   output logic [dpna_pkg::PIX_W-1:0]      rsp_pixel_value,
   output logic                            rsp_was_corrected,
   output logic                            rsp_out_of_frame,
   input  wire logic                       csr_write_enable,
   input  wire logic [dpna_pkg::IDX_W-1:0] csr_index,
   input  wire logic [dpna_pkg::CFG_W-1:0] csr_write_data
);

   dpna_pkg::cmd_type    cmd;
   dpna_pkg::status_type status;

   // Sequence each request
   dpna_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Store, checks and arithmetic
   dpna_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_load_value    (req_load_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_was_corrected (rsp_was_corrected),
      .rsp_out_of_frame  (rsp_out_of_frame)
   );

endmodule
`default_nettype wire

[src/dpna_checker.sv]
// Checker: port-level properties of the defect pixel neighbor average block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dpna_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_strobe,
   input wire logic [dpna_pkg::PIX_W-1:0] rsp_pixel_value,
   input wire logic                       rsp_was_corrected,
   input wire logic                       rsp_out_of_frame
);

   // An accepted request keeps the block busy in the next cycle
   `DPNA_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)

   // One request gives one strobe, never two in a row
   `DPNA_ASSERT(a_single_strobe, clock, reset, rsp_strobe |=> !rsp_strobe)

   // A result never arrives while a request is still in work
   `DPNA_ASSERT_NEVER(a_strobe_idle, clock, reset, rsp_strobe && busy)

   // Out-of-frame results carry no pixel and no correction
   `DPNA_ASSERT(a_oof_clean, clock, reset,
      (rsp_strobe && rsp_out_of_frame) |-> (!rsp_was_corrected && (rsp_pixel_value == '0)))

endmodule

bind defect_pixel_neighbor_average_top dpna_checker u_dpna_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_pixel_value   (rsp_pixel_value),
   .rsp_was_corrected (rsp_was_corrected),
   .rsp_out_of_frame  (rsp_out_of_frame)
);
`default_nettype wire
